FILE: hdl/sdr_pkg.sv
// ============================================================================
// sdr_pkg
// Shared types, constants and helpers for the spherical direction rotator.
// ============================================================================
package sdr_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;
    localparam int QW          = 36;
    localparam int ITERS       = 31;

    localparam int SC_LAT = ITERS + 2;
    localparam int AT_LAT = ITERS + 1;
    localparam int FR_LAT = SC_LAT + 2 * AT_LAT + 4;

    typedef logic signed [QW-1:0] t_q;
    typedef logic [31:0]          t_ang;

    typedef struct packed {
        t_ang azim;
        t_ang polar;
        logic pole;
    } t_stage;

    localparam t_q INV_GAIN = 36'sd652032874;
    localparam t_q QUARTER  = 36'sd1073741824;
    localparam t_q HALF     = 36'sd2147483648;

    localparam t_q ATAN_TAB [0:ITERS-1] = '{
        36'sd536870912, 36'sd316933406, 36'sd167458907, 36'sd85004756,
        36'sd42667331, 36'sd21354465, 36'sd10679838, 36'sd5340245,
        36'sd2670163, 36'sd1335087, 36'sd667544, 36'sd333772, 36'sd166886,
        36'sd83443, 36'sd41722, 36'sd20861, 36'sd10430, 36'sd5215,
        36'sd2608, 36'sd1304, 36'sd652, 36'sd326, 36'sd163, 36'sd81,
        36'sd41, 36'sd20, 36'sd10, 36'sd5, 36'sd3, 36'sd1, 36'sd1
    };

    // Product of two Q30 values, floored back to Q30. Both operands stay
    // within 32 signed bits.
    function automatic t_q mulq(input t_q a, input t_q b);
        logic signed [31:0] a_s;
        logic signed [31:0] b_s;
        logic signed [63:0] p;
        a_s = a[31:0];
        b_s = b[31:0];
        p   = a_s * b_s;
        return QW'(p >>> 30);
    endfunction

endpackage

FILE: hdl/sdr_sincos.sv
// ============================================================================
// sdr_sincos
// Pipelined rotation-mode CORDIC giving the sine and cosine of a binary angle.
// ============================================================================
module sdr_sincos import sdr_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_ang i_angle,
    output t_q   o_sin,
    output t_q   o_cos
);

    t_q   r_x   [0:ITERS];
    t_q   r_y   [0:ITERS];
    t_q   r_z   [0:ITERS];
    logic r_neg [0:ITERS];
    t_q   r_sin;
    t_q   r_cos;
    t_q   n_z;
    logic n_neg;

    always_comb begin
        n_z   = QW'($signed(i_angle));
        n_neg = 1'b0;
        if (n_z > QUARTER) begin
            n_z   = n_z - HALF;
            n_neg = 1'b1;
        end else if (n_z < -QUARTER) begin
            n_z   = n_z + HALF;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= INV_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= n_z;
            r_neg[0] <= n_neg;
            r_sin    <= r_neg[ITERS] ? -r_y[ITERS] : r_y[ITERS];
            r_cos    <= r_neg[ITERS] ? -r_x[ITERS] : r_x[ITERS];
        end
    end

    for (genvar g = 0; g < ITERS; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - ATAN_TAB[g];
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + ATAN_TAB[g];
                end
            end
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

FILE: hdl/sdr_atan2.sv
// ============================================================================
// sdr_atan2
// Pipelined vectoring-mode CORDIC giving the angle and scaled magnitude.
// ============================================================================
module sdr_atan2 import sdr_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_q   i_y,
    input  t_q   i_x,
    output t_q   o_z,
    output t_q   o_mag
);

    t_q r_x [0:ITERS];
    t_q r_y [0:ITERS];
    t_q r_z [0:ITERS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= HALF;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < ITERS; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[g] < 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - ATAN_TAB[g];
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + ATAN_TAB[g];
                end
            end
        end
    end

    assign o_z   = r_z[ITERS];
    assign o_mag = r_x[ITERS];

endmodule

FILE: hdl/sdr_frame.sv
// ============================================================================
// sdr_frame
// Re-expresses a direction in the frame whose pole is a given axis.
// ============================================================================
module sdr_frame import sdr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_ang   i_azim,
    input  t_ang   i_polar,
    input  t_ang   i_ax_azim,
    input  t_ang   i_ax_polar,
    output logic   o_valid,
    output t_stage o_res
);

    t_ang   n_d;
    t_q     w_sd, w_cd, w_st, w_ct, w_sa, w_ca;
    t_q     r_u, r_ctsa, r_ctca, r_x1, r_sa, r_ca;
    t_q     r_ss, r_c, r_x2;
    t_q     w_phi, w_xm, w_th, w_unused;
    t_q     r_mag;
    t_q     r_cd   [0:AT_LAT];
    t_q     r_phid [0:AT_LAT];
    t_ang   r_axd  [0:FR_LAT-2];
    logic   r_vd   [0:FR_LAT-1];
    t_stage r_res;
    t_q     n_th;
    t_q     n_az;
    logic [32:0] n_tq;
    t_stage n_res;

    assign n_d = i_azim - i_ax_azim;

    sdr_sincos u_sc_d (.i_clk, .i_en, .i_angle(n_d),        .o_sin(w_sd), .o_cos(w_cd));
    sdr_sincos u_sc_t (.i_clk, .i_en, .i_angle(i_polar),    .o_sin(w_st), .o_cos(w_ct));
    sdr_sincos u_sc_a (.i_clk, .i_en, .i_angle(i_ax_polar), .o_sin(w_sa), .o_cos(w_ca));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u    <= mulq(w_cd, w_st);
            r_ctsa <= mulq(w_ct, w_sa);
            r_ctca <= mulq(w_ct, w_ca);
            r_x1   <= mulq(-w_sd, w_st);
            r_sa   <= w_sa;
            r_ca   <= w_ca;
            r_ss   <= mulq(r_u, r_ca) - r_ctsa;
            r_c    <= mulq(r_u, r_sa) + r_ctca;
            r_x2   <= r_x1;
            r_mag  <= mulq(w_xm, INV_GAIN);
            r_cd[0]   <= r_c;
            r_phid[0] <= w_phi;
            for (int k = 1; k <= AT_LAT; k++) begin
                r_cd[k]   <= r_cd[k-1];
                r_phid[k] <= r_phid[k-1];
            end
            r_axd[0] <= i_ax_azim;
            for (int k = 1; k <= FR_LAT - 2; k++) begin
                r_axd[k] <= r_axd[k-1];
            end
            r_res <= n_res;
        end
    end

    sdr_atan2 u_at_az (.i_clk, .i_en, .i_y(r_ss),  .i_x(r_x2),
                       .o_z(w_phi), .o_mag(w_xm));
    sdr_atan2 u_at_po (.i_clk, .i_en, .i_y(r_mag), .i_x(r_cd[AT_LAT]),
                       .o_z(w_th), .o_mag(w_unused));

    always_comb begin
        n_th = w_th;
        if (n_th < 0) begin
            n_th = '0;
        end
        if (n_th > HALF) begin
            n_th = HALF;
        end
        n_az = r_phid[AT_LAT] + QW'(r_axd[FR_LAT-2]) - QUARTER;
        n_tq = {1'b0, n_th[31:0]} + 33'(1 << (ANGLE_SHIFT - 1));
        n_res.polar = n_th[31:0];
        n_res.pole  = (n_tq[32:ANGLE_SHIFT] == '0)
                   || (n_tq[32:ANGLE_SHIFT] == (33 - ANGLE_SHIFT)'(1 << (ANGLE_BITS - 1)));
        n_res.azim  = n_res.pole ? '0 : n_az[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FR_LAT; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vd[0] <= i_valid;
            for (int k = 1; k < FR_LAT; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
    end

    assign o_valid = r_vd[FR_LAT-1];
    assign o_res   = r_res;

endmodule

FILE: hdl/spherical_direction_rotator.sv
// ============================================================================
// spherical_direction_rotator
// Throughput: one beat per cycle; the pipeline advances while its skid stage
// is empty, so one waiting output beat does not stop the input.
// Reset: synchronous, active low; clears the valid bits of every stage.
// Rotates a direction about an axis through two CORDIC frame changes.
// ============================================================================
module spherical_direction_rotator import sdr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // point_azimuth, point_polar, axis_azimuth, axis_polar, turn_angle
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_azimuth, result_polar
    output logic [31:0] m_axis_tdata,
    // pole_hit
    output logic        m_axis_tuser
);

    localparam logic [ANGLE_BITS-1:0] POLE_IN = ANGLE_BITS'(1 << (ANGLE_BITS - 1));

    logic   en;
    logic   r_in_vld;
    t_ang   r_paz, r_ppol, r_aaz, r_apol, r_turn;
    t_ang   r_aaz_d  [0:FR_LAT-1];
    t_ang   r_apol_d [0:FR_LAT-1];
    t_ang   r_turn_d [0:FR_LAT-1];
    logic   r_pole_d [0:FR_LAT-1];
    logic   f1_vld, f2_vld;
    t_stage f1_res, f2_res;
    logic   r_m_vld, r_m_pole;
    t_ang   r_m_az, r_m_pol, r_m_axaz, r_m_axpol;
    logic   r_t_vld, r_t_pole;
    logic [31:0] r_t_data;
    logic   r_o_vld, r_o_pole;
    logic [31:0] r_o_data;
    logic   r_s_vld, r_s_pole;
    logic [31:0] r_s_data;
    logic [ANGLE_BITS-1:0] n_pp, n_ap;
    logic [32:0] n_raz, n_rpol;

    assign en            = !r_s_vld;
    assign s_axis_tready = en;

    always_comb begin
        n_pp = s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
        n_ap = s_axis_tdata[4*ANGLE_BITS-1:3*ANGLE_BITS];
        if (n_pp > POLE_IN) begin
            n_pp = POLE_IN;
        end
        if (n_ap > POLE_IN) begin
            n_ap = POLE_IN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_paz  <= {s_axis_tdata[ANGLE_BITS-1:0], {ANGLE_SHIFT{1'b0}}};
            r_ppol <= {n_pp, {ANGLE_SHIFT{1'b0}}};
            r_aaz  <= {s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS], {ANGLE_SHIFT{1'b0}}};
            r_apol <= {n_ap, {ANGLE_SHIFT{1'b0}}};
            r_turn <= {s_axis_tdata[5*ANGLE_BITS-1:4*ANGLE_BITS], {ANGLE_SHIFT{1'b0}}};
            r_aaz_d[0]  <= r_aaz;
            r_apol_d[0] <= r_apol;
            r_turn_d[0] <= r_turn;
            r_pole_d[0] <= r_m_pole;
            for (int k = 1; k < FR_LAT; k++) begin
                r_aaz_d[k]  <= r_aaz_d[k-1];
                r_apol_d[k] <= r_apol_d[k-1];
                r_turn_d[k] <= r_turn_d[k-1];
                r_pole_d[k] <= r_pole_d[k-1];
            end
            r_m_az    <= f1_res.azim + r_turn_d[FR_LAT-1];
            r_m_pol   <= f1_res.polar;
            r_m_axaz  <= r_aaz_d[FR_LAT-1] + 32'h8000_0000;
            r_m_axpol <= r_apol_d[FR_LAT-1];
            r_m_pole  <= f1_res.pole;
            r_t_data  <= {n_rpol[ANGLE_SHIFT+ANGLE_BITS-1:ANGLE_SHIFT],
                          n_raz[ANGLE_SHIFT+ANGLE_BITS-1:ANGLE_SHIFT]};
            r_t_pole  <= f2_res.pole | r_pole_d[FR_LAT-1];
        end
    end

    assign n_raz  = {1'b0, f2_res.azim}  + 33'(1 << (ANGLE_SHIFT - 1));
    assign n_rpol = {1'b0, f2_res.polar} + 33'(1 << (ANGLE_SHIFT - 1));

    sdr_frame u_frame_in (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_in_vld),
        .i_azim(r_paz), .i_polar(r_ppol), .i_ax_azim(r_aaz), .i_ax_polar(r_apol),
        .o_valid(f1_vld), .o_res(f1_res)
    );

    sdr_frame u_frame_out (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_m_vld),
        .i_azim(r_m_az), .i_polar(r_m_pol), .i_ax_azim(r_m_axaz), .i_ax_polar(r_m_axpol),
        .o_valid(f2_vld), .o_res(f2_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_m_vld  <= 1'b0;
            r_t_vld  <= 1'b0;
        end else if (en) begin
            r_in_vld <= s_axis_tvalid;
            r_m_vld  <= f1_vld;
            r_t_vld  <= f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else begin
            if (en && r_t_vld && r_o_vld && !m_axis_tready) begin
                r_s_vld  <= 1'b1;
                r_s_data <= r_t_data;
                r_s_pole <= r_t_pole;
            end
            if (!r_o_vld || m_axis_tready) begin
                if (r_s_vld) begin
                    r_o_vld  <= 1'b1;
                    r_o_data <= r_s_data;
                    r_o_pole <= r_s_pole;
                    r_s_vld  <= 1'b0;
                end else if (en && r_t_vld) begin
                    r_o_vld  <= 1'b1;
                    r_o_data <= r_t_data;
                    r_o_pole <= r_t_pole;
                end else begin
                    r_o_vld <= 1'b0;
                end
            end
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_pole;

endmodule

FILE: bench/tb_spherical_direction_rotator.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_spherical_direction_rotator
// Drives directed and random directions, axes and turn angles into the
// rotator, predicts every output beat with a bit-exact CORDIC model and
// checks each beat in order, under random idling on both sides.
// ============================================================================
module tb_spherical_direction_rotator;
    import sdr_pkg::*;

    localparam longint TURN    = 64'sd4294967296;
    localparam longint HALF_T  = 64'sd2147483648;
    localparam longint QUART_T = 64'sd1073741824;
    localparam longint KINV    = 64'sd652032874;
    localparam int     NCORD   = 31;
    localparam int     WD_LIMIT = 5000;

    localparam longint ARC_TAB [0:NCORD-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1
    };

    typedef struct {
        logic [15:0] azim;
        logic [15:0] polar;
        logic        pole;
    } t_rotated;

    typedef struct {
        longint azim;
        longint polar;
        bit     pole;
    } t_frame;

    function automatic longint fix_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint wrap_turn(input longint v);
        return v & 64'hFFFF_FFFF;
    endfunction

    function automatic void cordic_sin_cos(input longint ang, output longint sn,
                                           output longint cs);
        longint z, x, y, dx, dy;
        bit neg;
        z = wrap_turn(ang);
        if (z >= HALF_T) z -= TURN;
        neg = 0;
        x = KINV;
        y = 0;
        if (z > QUART_T) begin
            z -= HALF_T; neg = 1;
        end else if (z < -QUART_T) begin
            z += HALF_T; neg = 1;
        end
        for (int i = 0; i < NCORD; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARC_TAB[i];
            end else begin
                x += dx; y -= dy; z += ARC_TAB[i];
            end
        end
        sn = neg ? -y : y;
        cs = neg ? -x : x;
    endfunction

    function automatic longint cordic_atan2(input longint yi, input longint xi,
                                            output longint mag);
        longint x, y, z, dx, dy;
        x = xi;
        y = yi;
        z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = HALF_T;
        end
        for (int i = 0; i < NCORD; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= ARC_TAB[i];
            end else begin
                x += dx; y -= dy; z += ARC_TAB[i];
            end
        end
        mag = fix_mul(x, KINV);
        return z;
    endfunction

    function automatic longint round_angle(input longint v);
        return ((v + 64'sd32768) >>> 16) & 64'hFFFF;
    endfunction

    function automatic t_frame change_frame(input longint az, input longint pol,
                                            input longint ax_az, input longint ax_pol);
        t_frame r;
        longint sd, cd, st, ct, sa, ca, u, ss, c, x, mag, phi, th, rq;
        cordic_sin_cos(wrap_turn(az - ax_az), sd, cd);
        cordic_sin_cos(pol, st, ct);
        cordic_sin_cos(ax_pol, sa, ca);
        u  = fix_mul(cd, st);
        ss = fix_mul(u, ca) - fix_mul(ct, sa);
        c  = fix_mul(u, sa) + fix_mul(ct, ca);
        x  = fix_mul(-sd, st);
        phi = cordic_atan2(ss, x, mag);
        th  = cordic_atan2(mag, c, mag);
        if (th < 0) th = 0;
        if (th > HALF_T) th = HALF_T;
        r.polar = th;
        r.azim  = wrap_turn(phi + ax_az - QUART_T);
        rq = round_angle(th);
        r.pole = (rq == 0) || (rq == 32768);
        if (r.pole) r.azim = 0;
        return r;
    endfunction

    function automatic t_rotated rotate_direction(input logic [79:0] d);
        longint p_az, p_pol, a_az, a_pol, turn;
        t_frame s1, s2;
        t_rotated o;
        p_az  = longint'(d[15:0]) <<< 16;
        p_pol = (d[31:16] > 16'd32768) ? 64'sd32768 : longint'(d[31:16]);
        p_pol = p_pol <<< 16;
        a_az  = longint'(d[47:32]) <<< 16;
        a_pol = (d[63:48] > 16'd32768) ? 64'sd32768 : longint'(d[63:48]);
        a_pol = a_pol <<< 16;
        turn  = longint'(d[79:64]) <<< 16;
        s1 = change_frame(p_az, p_pol, a_az, a_pol);
        s2 = change_frame(wrap_turn(s1.azim + turn), s1.polar,
                          wrap_turn(a_az + HALF_T), a_pol);
        o.azim  = 16'(round_angle(s2.azim));
        o.polar = 16'(round_angle(s2.polar));
        o.pole  = s1.pole || s2.pole;
        return o;
    endfunction

    class rotation_scoreboard;
        t_rotated expected_q[$];
        int errors = 0;

        function void note_input(logic [79:0] d);
            expected_q.push_back(rotate_direction(d));
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [31:0] d, logic u);
            t_rotated e;
            if (expected_q.size() == 0) begin
                report("output beat with none expected", longint'(d), 0);
                return;
            end
            e = expected_q.pop_front();
            if (d[15:0] !== e.azim) report("result_azimuth", d[15:0], e.azim);
            if (d[31:16] !== e.polar) report("result_polar", d[31:16], e.polar);
            if (u !== e.pole) report("pole_hit", u, e.pole);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    rotation_scoreboard sb = new();
    bit  hold_output = 0;
    int  idle_cycles = 0;
    int  gap_mode = 0;

    spherical_direction_rotator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gap_mode == 0) return 0;
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_beat(input logic [15:0] paz, input logic [15:0] ppol,
                             input logic [15:0] aaz, input logic [15:0] apol,
                             input logic [15:0] turn);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {turn, apol, aaz, ppol, paz};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] rand_polar();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 16'd0;
        if (r < 8) return 16'd32768;
        if (r < 14) return 16'($urandom_range(32769, 65535));
        return 16'($urandom_range(0, 32768));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int r;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                m_axis_tready <= 1'b0;
                repeat (450) @(posedge i_clk);
                hold_output = 0;
            end
            r = $urandom_range(0, 99);
            if (gap_mode == 0 || r < 70)
                m_axis_tready <= 1'b1;
            else if (r < 97)
                m_axis_tready <= 1'b0;
            else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_beat(16'hFFFF, 16'd32768, 16'hFFFF, 16'd32768, 16'h7FFF);
        send_beat(16'd1000, 16'hFFFF, 16'd2000, 16'hFFFF, 16'h8000);
        send_beat(16'd12345, 16'd16384, 16'd0, 16'd0, 16'd16384);
        send_beat(16'd12345, 16'd16384, 16'd0, 16'd32768, 16'hC000);
        send_beat(16'd5000, 16'd9000, 16'd5000, 16'd9000, 16'd1234);
        send_beat(16'd5000, 16'd9000, 16'd37768, 16'd23768, 16'd4321);
        send_beat(16'd0, 16'd16384, 16'd0, 16'd16384, 16'd32767);
        send_beat(16'd16384, 16'd16384, 16'd0, 16'd16384, 16'h8000);
        send_beat(16'd40000, 16'd32768, 16'd100, 16'd16384, 16'd16384);
        send_beat(16'd40000, 16'd0, 16'd100, 16'd16384, 16'hC000);
        send_beat(16'hAAAA, 16'h5555, 16'h5555, 16'h2AAA, 16'hAAAA);
        send_beat(16'h5555, 16'h2AAA, 16'hAAAA, 16'h5555, 16'h5555);
        send_beat(16'd1, 16'd1, 16'd65535, 16'd32767, 16'hFFFF);
        send_beat(16'd32768, 16'd32767, 16'd32768, 16'd1, 16'd1);
        send_beat(16'd8192, 16'd8192, 16'd8192, 16'd8192, 16'd0);

        gap_mode = 1;
        hold_output = 1;
        for (int n = 0; n < 950; n++) begin
            if (n % 200 == 199) gap_mode = 0;
            else if (n % 200 == 0) gap_mode = 1;
            send_beat(16'($urandom), rand_polar(), 16'($urandom), rand_polar(),
                      16'($urandom));
        end
        s_axis_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
